// ===== hdl/i2cmts_pkg.sv =====
// shared types, codes and sizes for the i2c master transaction sequencer
package i2cmts_pkg;

  localparam int TX_DEPTH = 128;
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int TX_CW    = $clog2(TX_DEPTH + 1);

  localparam logic [2:0] MODE_LOAD     = 3'd0;
  localparam logic [2:0] MODE_START    = 3'd1;
  localparam logic [2:0] MODE_SENT     = 3'd2;
  localparam logic [2:0] MODE_DONE     = 3'd3;
  localparam logic [2:0] MODE_RX_READY = 3'd4;
  localparam logic [2:0] MODE_ERROR    = 3'd5;

  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_ADDR      = 3'd1;
  localparam logic [2:0] ACT_DATA      = 3'd2;
  localparam logic [2:0] ACT_RESTART   = 3'd3;
  localparam logic [2:0] ACT_STOP      = 3'd4;
  localparam logic [2:0] ACT_NACK_STOP = 3'd5;

  typedef struct packed {
    logic [2:0] mode;
    logic [6:0] tx_index;
    logic [7:0] tx_byte;
    logic [7:0] slave_address;
    logic [7:0] tx_count;
    logic [7:0] rx_count;
    logic [7:0] rx_byte;
  } cmd_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] bus_byte;
    logic       rx_valid;
    logic [7:0] rx_data;
    logic       rx_last;
    logic       busy_res;
    logic       rejected;
  } res_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } ctl_t;

endpackage

// ===== hdl/i2cmts_ctrl.sv =====
// handshake controller: takes an item, then commits its result to the output register
module i2cmts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  output logic              res_valid,
  input  logic              res_stall,
  output i2cmts_pkg::ctl_t  ctl
);
  import i2cmts_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state;

  assign cmd_stall   = (state != S_IDLE);
  assign ctl.capture = (state == S_IDLE) && cmd_valid;
  assign ctl.commit  = (state == S_EXEC) && (!res_valid || !res_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ctl.commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      res_valid <= ctl.commit || (res_valid && res_stall);
    end
  end

endmodule

// ===== hdl/i2cmts_dpath.sv =====
// datapath: transmit buffer, transaction state and result register
module i2cmts_dpath (
  input  logic              clk,
  input  logic              rst,
  input  i2cmts_pkg::ctl_t  ctl,
  input  i2cmts_pkg::cmd_t  cmd,
  output i2cmts_pkg::res_t  res
);
  import i2cmts_pkg::*;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_WRITE,
    PH_PREREAD,
    PH_READ
  } phase_t;

  logic [7:0]       tx_buffer [TX_DEPTH];
  logic [7:0]       rdata;
  cmd_t             item;
  phase_t           phase, phase_next;
  logic [TX_CW-1:0] tx_remaining, tx_remaining_next;
  logic [7:0]       rx_remaining, rx_remaining_next;
  logic [TX_AW-1:0] byte_index, byte_index_next;
  logic [7:0]       target_address, target_address_next;
  logic             wr_en;
  res_t             result;
  logic             busy;
  logic [TX_AW-1:0] byte_index_inc;

  assign busy = (phase != PH_IDLE);
  assign byte_index_inc = (byte_index == TX_AW'(TX_DEPTH - 1)) ? '0 :
                          byte_index + TX_AW'(1);

  always_comb begin
    phase_next          = phase;
    tx_remaining_next   = tx_remaining;
    rx_remaining_next   = rx_remaining;
    byte_index_next     = byte_index;
    target_address_next = target_address;
    wr_en               = 1'b0;
    result              = '0;
    case (item.mode)
      MODE_LOAD: begin
        if (busy) begin
          result.rejected = 1'b1;
        end else if (9'(item.tx_index) < 9'(TX_DEPTH)) begin
          wr_en = 1'b1;
        end
      end
      MODE_START: begin
        if (busy) begin
          result.rejected = 1'b1;
        end else begin
          target_address_next = item.slave_address;
          tx_remaining_next   = (9'(item.tx_count) > 9'(TX_DEPTH)) ?
                                TX_CW'(TX_DEPTH) : TX_CW'(item.tx_count);
          rx_remaining_next   = item.rx_count;
          byte_index_next     = '0;
          phase_next          = (item.rx_count == 8'd0) ? PH_WRITE : PH_PREREAD;
        end
      end
      MODE_SENT: begin
        if (phase == PH_WRITE || phase == PH_PREREAD) begin
          result.bus_action = ACT_ADDR;
          result.bus_byte   = {target_address[7:1], 1'b0};
          byte_index_next   = '0;
        end else if (phase == PH_READ) begin
          result.bus_action = ACT_ADDR;
          result.bus_byte   = {target_address[7:1], 1'b1};
          byte_index_next   = '0;
        end
      end
      MODE_DONE: begin
        if (phase == PH_WRITE || phase == PH_PREREAD) begin
          if (tx_remaining == '0) begin
            if (phase == PH_WRITE) begin
              result.bus_action = ACT_STOP;
              phase_next        = PH_IDLE;
            end else begin
              result.bus_action = ACT_RESTART;
              phase_next        = PH_READ;
              byte_index_next   = '0;
            end
          end else begin
            result.bus_action = ACT_DATA;
            result.bus_byte   = rdata;
            byte_index_next   = byte_index_inc;
            tx_remaining_next = tx_remaining - TX_CW'(1);
          end
        end
      end
      MODE_RX_READY: begin
        if (phase == PH_READ) begin
          result.rx_valid = 1'b1;
          result.rx_data  = item.rx_byte;
          if (rx_remaining <= 8'd1) begin
            rx_remaining_next = '0;
            result.rx_last    = 1'b1;
            result.bus_action = ACT_NACK_STOP;
            phase_next        = PH_IDLE;
          end else begin
            rx_remaining_next = rx_remaining - 8'd1;
          end
        end
      end
      MODE_ERROR: begin
        result.bus_action = ACT_STOP;
        phase_next        = PH_IDLE;
      end
      default: begin
      end
    endcase
    result.busy_res = (phase_next != PH_IDLE);
  end

  // buffer read tracks byte_index so the data byte is ready when the item executes
  always_ff @(posedge clk) begin
    rdata <= tx_buffer[byte_index];
    if (ctl.commit && wr_en) begin
      tx_buffer[TX_AW'(item.tx_index)] <= item.tx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      item <= cmd;
    end
    if (ctl.commit) begin
      res <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tx_remaining   <= '0;
      rx_remaining   <= '0;
      byte_index     <= '0;
      target_address <= '0;
    end else if (ctl.commit) begin
      phase          <= phase_next;
      tx_remaining   <= tx_remaining_next;
      rx_remaining   <= rx_remaining_next;
      byte_index     <= byte_index_next;
      target_address <= target_address_next;
    end
  end

endmodule

// ===== hdl/i2c_master_transaction_sequencer_unit.sv =====
// top level of the i2c master transaction sequencer
//
//   port group             dir   role
//   cmd_valid/stall/cmd    in    load, start and bus engine event items
//   res_valid/stall/res    out   one result item per command item
//
// each item is first captured into the item register, then executed, which loads
// the output register; the transmit buffer read is registered in between.
// a new item is taken while the previous result still waits in the output register.
// a stalled output holds the next item in execution until the register frees.
// reset clears the controller and transaction state; the buffer is not cleared.
module i2c_master_transaction_sequencer_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_stall,
  input  i2cmts_pkg::cmd_t  cmd,
  output logic              res_valid,
  input  logic              res_stall,
  output i2cmts_pkg::res_t  res
);
  import i2cmts_pkg::*;

  ctl_t ctl;

  i2cmts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .ctl       (ctl)
  );

  i2cmts_dpath u_dpath (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .cmd (cmd),
    .res (res)
  );

  a_accept_then_busy: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("accepted item did not move into execution");

  a_commit_only_in_exec: assert property (@(posedge clk) disable iff (rst)
    ctl.commit |-> (cmd_stall && !ctl.capture))
    else $error("commit outside execution");

  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(ctl.commit))
    else $error("result appeared without a commit");

  a_last_rx: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.rx_last) |->
      (res.rx_valid && !res.busy_res && res.bus_action == ACT_NACK_STOP))
    else $error("last received byte without nack and stop");

endmodule
